// ===== src/clpe_pkg.sv =====
// ----------------------------------------------------------------------------
// clpe_pkg
// shared constants, codes and controller/datapath interface types for the
// circular list position engine
// ----------------------------------------------------------------------------
package clpe_pkg;

  localparam int DEPTH  = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int DATA_W = 32;
  localparam int POS_W  = 8;
  localparam int FUNC_W = 4;
  localparam int STAT_W = 3;
  localparam int OUT_W  = 7;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_FRONT = 4'd0,
    FN_INS_END   = 4'd1,
    FN_INS_AT    = 4'd2,
    FN_DEL_FRONT = 4'd3,
    FN_DEL_END   = 4'd4,
    FN_DEL_AT    = 4'd5,
    FN_SEARCH    = 4'd6,
    FN_REVERSE   = 4'd7,
    FN_DUMP      = 4'd8
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_BADPOS  = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  // pointer setup on request accept
  typedef enum logic [2:0] {
    LD_INS_FRONT = 3'd0,
    LD_INS_END   = 3'd1,
    LD_INS_AT    = 3'd2,
    LD_DEL_FRONT = 3'd3,
    LD_DEL_END   = 3'd4,
    LD_DEL_AT    = 3'd5,
    LD_SCAN      = 3'd6,
    LD_REV       = 3'd7
  } ld_t;

  typedef enum logic [1:0] {
    RA_A   = 2'd0,
    RA_AM1 = 2'd1,
    RA_AP1 = 2'd2,
    RA_B   = 2'd3
  } ra_t;

  typedef enum logic {
    WA_A = 1'b0,
    WA_B = 1'b1
  } wa_t;

  typedef enum logic [1:0] {
    WD_VAL = 2'd0,
    WD_RD  = 2'd1,
    WD_TMP = 2'd2
  } wd_t;

  typedef enum logic [1:0] {
    DS_ZERO = 2'd0,
    DS_TMP  = 2'd1,
    DS_RD   = 2'd2
  } dsel_t;

  typedef enum logic {
    FS_ZERO = 1'b0,
    FS_AP1  = 1'b1
  } fsel_t;

  typedef struct packed {
    logic    ld;
    ld_t     ld_sel;
    logic    rd_en;
    ra_t     ra_sel;
    logic    wr_en;
    wa_t     wa_sel;
    wd_t     wd_sel;
    logic    tmp_ld;
    logic    a_inc;
    logic    a_dec;
    logic    b_dec;
    logic    k_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    emit;
    status_t emit_st;
    dsel_t   data_sel;
    fsel_t   fpos_sel;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic cnt_full;
    logic pos_le1;
    logic k_zero;
    logic k_one;
    logic match;
  } sts_t;

endpackage

// ===== src/clpe_ctrl.sv =====
// ----------------------------------------------------------------------------
// clpe_ctrl
// request decode and sequencing state machine; walks the list with at most one
// memory access per cycle and steers the datapath through command signals
// ----------------------------------------------------------------------------
module clpe_ctrl
  import clpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [FUNC_W-1:0] in_func,
  input  sts_t              sts,
  output cmd_t              cmd,
  output logic              busy
);

  typedef enum logic [14:0] {
    S_IDLE      = 15'b000000000000001,
    S_INS_RD    = 15'b000000000000010,
    S_INS_WR    = 15'b000000000000100,
    S_DEL_RD0   = 15'b000000000001000,
    S_DEL_CAP   = 15'b000000000010000,
    S_DEL_RD    = 15'b000000000100000,
    S_DEL_WR    = 15'b000000001000000,
    S_SRCH_RD   = 15'b000000010000000,
    S_SRCH_CMP  = 15'b000000100000000,
    S_REV_RDA   = 15'b000001000000000,
    S_REV_RDB   = 15'b000010000000000,
    S_REV_WRA   = 15'b000100000000000,
    S_REV_WRB   = 15'b001000000000000,
    S_DUMP_RD   = 15'b010000000000000,
    S_DUMP_EMIT = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.ld   = 1'b1;
          cmd.last = 1'b1;
          unique case (in_func)
            FN_INS_FRONT, FN_INS_END, FN_INS_AT: begin
              cmd.ld_sel = (in_func == FN_INS_FRONT) ? LD_INS_FRONT :
                           (in_func == FN_INS_END)   ? LD_INS_END : LD_INS_AT;
              if (sts.cnt_full) begin
                cmd.emit    = 1'b1;
                cmd.emit_st = ST_FULL;
              end else begin
                state_nxt = S_INS_RD;
              end
            end
            FN_DEL_FRONT, FN_DEL_END, FN_DEL_AT: begin
              cmd.ld_sel = (in_func == FN_DEL_FRONT) ? LD_DEL_FRONT :
                           (in_func == FN_DEL_END)   ? LD_DEL_END : LD_DEL_AT;
              priority if (sts.cnt_zero) begin
                cmd.emit    = 1'b1;
                cmd.emit_st = ST_EMPTY;
              end else if (in_func == FN_DEL_AT && sts.cnt_one && !sts.pos_le1) begin
                cmd.emit    = 1'b1;
                cmd.emit_st = ST_BADPOS;
              end else begin
                state_nxt = S_DEL_RD0;
              end
            end
            FN_SEARCH: begin
              cmd.ld_sel = LD_SCAN;
              if (sts.cnt_zero) begin
                cmd.emit    = 1'b1;
                cmd.emit_st = ST_EMPTY;
              end else begin
                state_nxt = S_SRCH_RD;
              end
            end
            FN_REVERSE: begin
              cmd.ld_sel = LD_REV;
              state_nxt  = S_REV_RDA;
            end
            FN_DUMP: begin
              cmd.ld_sel = LD_SCAN;
              if (sts.cnt_zero) begin
                cmd.emit    = 1'b1;
                cmd.emit_st = ST_EMPTY;
              end else begin
                state_nxt = S_DUMP_RD;
              end
            end
            default: begin
              cmd.emit    = 1'b1;
              cmd.emit_st = ST_OK;
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (sts.k_zero) begin
          cmd.wr_en   = 1'b1;
          cmd.wa_sel  = WA_A;
          cmd.wd_sel  = WD_VAL;
          cmd.cnt_inc = 1'b1;
          cmd.emit    = 1'b1;
          cmd.emit_st = ST_OK;
          cmd.last    = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = RA_AM1;
          state_nxt  = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_A;
        cmd.wd_sel = WD_RD;
        cmd.a_dec  = 1'b1;
        cmd.k_dec  = 1'b1;
        state_nxt  = S_INS_RD;
      end
      S_DEL_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.ra_sel = RA_A;
        state_nxt  = S_DEL_CAP;
      end
      S_DEL_CAP: begin
        cmd.tmp_ld = 1'b1;
        state_nxt  = S_DEL_RD;
      end
      S_DEL_RD: begin
        if (sts.k_zero) begin
          cmd.cnt_dec  = 1'b1;
          cmd.emit     = 1'b1;
          cmd.emit_st  = ST_OK;
          cmd.data_sel = DS_TMP;
          cmd.last     = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = RA_AP1;
          state_nxt  = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_A;
        cmd.wd_sel = WD_RD;
        cmd.a_inc  = 1'b1;
        cmd.k_dec  = 1'b1;
        state_nxt  = S_DEL_RD;
      end
      S_SRCH_RD: begin
        if (sts.k_zero) begin
          cmd.emit    = 1'b1;
          cmd.emit_st = ST_MISSING;
          cmd.last    = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = RA_A;
          state_nxt  = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (sts.match) begin
          cmd.emit     = 1'b1;
          cmd.emit_st  = ST_OK;
          cmd.fpos_sel = FS_AP1;
          cmd.last     = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.a_inc = 1'b1;
          cmd.k_dec = 1'b1;
          state_nxt = S_SRCH_RD;
        end
      end
      S_REV_RDA: begin
        if (sts.k_zero) begin
          cmd.emit    = 1'b1;
          cmd.emit_st = ST_OK;
          cmd.last    = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = RA_A;
          state_nxt  = S_REV_RDB;
        end
      end
      S_REV_RDB: begin
        cmd.tmp_ld = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.ra_sel = RA_B;
        state_nxt  = S_REV_WRA;
      end
      S_REV_WRA: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_A;
        cmd.wd_sel = WD_RD;
        state_nxt  = S_REV_WRB;
      end
      S_REV_WRB: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_B;
        cmd.wd_sel = WD_TMP;
        cmd.a_inc  = 1'b1;
        cmd.b_dec  = 1'b1;
        cmd.k_dec  = 1'b1;
        state_nxt  = S_REV_RDA;
      end
      S_DUMP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.ra_sel = RA_A;
        state_nxt  = S_DUMP_EMIT;
      end
      S_DUMP_EMIT: begin
        cmd.emit     = 1'b1;
        cmd.emit_st  = ST_OK;
        cmd.data_sel = DS_RD;
        cmd.fpos_sel = FS_AP1;
        cmd.last     = sts.k_one;
        cmd.a_inc    = 1'b1;
        cmd.k_dec    = 1'b1;
        state_nxt    = sts.k_one ? S_IDLE : S_DUMP_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/clpe_dpath.sv =====
// ----------------------------------------------------------------------------
// clpe_dpath
// entry memory, list pointers, entry count and result register; one read
// and one write of the entry memory per cycle
// ----------------------------------------------------------------------------
module clpe_dpath
  import clpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [DATA_W-1:0] in_value,
  input  logic [POS_W-1:0]  in_position,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              out_strobe,
  output logic [STAT_W-1:0] out_status,
  output logic [DATA_W-1:0] out_data,
  output logic [OUT_W-1:0]  out_found_position,
  output logic [OUT_W-1:0]  out_count,
  output logic              out_last
);

  logic [DATA_W-1:0] entries_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic [DATA_W-1:0] val_r, tmp_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  a_r, a_nxt;
  logic [CNT_W-1:0]  b_r, b_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              out_strobe_r;
  logic [STAT_W-1:0] out_status_r;
  logic [DATA_W-1:0] out_data_r;
  logic [OUT_W-1:0]  out_fpos_r;
  logic [OUT_W-1:0]  out_count_r;
  logic              out_last_r;

  logic [CNT_W-1:0]  cnt_m1, a_m1, a_p1;
  logic [POS_W-1:0]  pos_m1;
  logic              pos_le1;
  logic [CNT_W-1:0]  ins_at_idx, del_at_idx;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [DATA_W-1:0] wr_data, emit_data;

  assign cnt_m1  = cnt_r - 1'b1;
  assign a_m1    = a_r - 1'b1;
  assign a_p1    = a_r + 1'b1;
  assign pos_m1  = in_position - 1'b1;
  assign pos_le1 = (in_position <= POS_W'(1));

  // clamp positions to the current list length
  always_comb begin
    if (cnt_r == '0 || pos_le1) begin
      ins_at_idx = '0;
    end else if (pos_m1 > POS_W'(cnt_r)) begin
      ins_at_idx = cnt_r;
    end else begin
      ins_at_idx = CNT_W'(pos_m1);
    end
    if (pos_le1) begin
      del_at_idx = '0;
    end else if (pos_m1 > POS_W'(cnt_m1)) begin
      del_at_idx = cnt_m1;
    end else begin
      del_at_idx = CNT_W'(pos_m1);
    end
  end

  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.cnt_one  = (cnt_r == CNT_W'(1));
  assign sts.cnt_full = (cnt_r == CNT_W'(DEPTH));
  assign sts.pos_le1  = pos_le1;
  assign sts.k_zero   = (k_r == '0);
  assign sts.k_one    = (k_r == CNT_W'(1));
  assign sts.match    = (rd_data_r == val_r);

  // pointer and count update
  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    k_nxt   = k_r;
    cnt_nxt = cnt_r;
    if (cmd.ld) begin
      unique case (cmd.ld_sel)
        LD_INS_FRONT: begin
          a_nxt = cnt_r;
          k_nxt = cnt_r;
        end
        LD_INS_END: begin
          a_nxt = cnt_r;
          k_nxt = '0;
        end
        LD_INS_AT: begin
          a_nxt = cnt_r;
          k_nxt = cnt_r - ins_at_idx;
        end
        LD_DEL_FRONT: begin
          a_nxt = '0;
          k_nxt = cnt_m1;
        end
        LD_DEL_END: begin
          a_nxt = cnt_m1;
          k_nxt = '0;
        end
        LD_DEL_AT: begin
          a_nxt = del_at_idx;
          k_nxt = cnt_m1 - del_at_idx;
        end
        LD_SCAN: begin
          a_nxt = '0;
          k_nxt = cnt_r;
        end
        LD_REV: begin
          a_nxt = '0;
          b_nxt = cnt_m1;
          k_nxt = cnt_r >> 1;
        end
        default: begin
          a_nxt = '0;
        end
      endcase
    end else begin
      if (cmd.a_inc) a_nxt = a_p1;
      if (cmd.a_dec) a_nxt = a_m1;
      if (cmd.b_dec) b_nxt = b_r - 1'b1;
      if (cmd.k_dec) k_nxt = k_r - 1'b1;
    end
    if (cmd.cnt_inc) cnt_nxt = cnt_r + 1'b1;
    if (cmd.cnt_dec) cnt_nxt = cnt_m1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      a_r   <= '0;
      b_r   <= '0;
      k_r   <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      k_r   <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld) val_r <= in_value;
    if (cmd.tmp_ld) tmp_r <= rd_data_r;
  end

  // entry memory
  always_comb begin
    unique case (cmd.ra_sel)
      RA_A:    rd_addr = a_r[IDX_W-1:0];
      RA_AM1:  rd_addr = a_m1[IDX_W-1:0];
      RA_AP1:  rd_addr = a_p1[IDX_W-1:0];
      RA_B:    rd_addr = b_r[IDX_W-1:0];
      default: rd_addr = a_r[IDX_W-1:0];
    endcase
    wr_addr = (cmd.wa_sel == WA_B) ? b_r[IDX_W-1:0] : a_r[IDX_W-1:0];
    unique case (cmd.wd_sel)
      WD_VAL:  wr_data = val_r;
      WD_RD:   wr_data = rd_data_r;
      WD_TMP:  wr_data = tmp_r;
      default: wr_data = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) entries_r[wr_addr] <= wr_data;
    if (cmd.rd_en) rd_data_r <= entries_r[rd_addr];
  end

  // result register
  always_comb begin
    unique case (cmd.data_sel)
      DS_ZERO: emit_data = '0;
      DS_TMP:  emit_data = tmp_r;
      DS_RD:   emit_data = rd_data_r;
      default: emit_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.emit_st;
      out_data_r   <= emit_data;
      out_fpos_r   <= (cmd.fpos_sel == FS_AP1) ? OUT_W'(a_p1) : '0;
      out_count_r  <= OUT_W'(cnt_nxt);
      out_last_r   <= cmd.last;
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_status         = out_status_r;
  assign out_data           = out_data_r;
  assign out_found_position = out_fpos_r;
  assign out_count          = out_count_r;
  assign out_last           = out_last_r;

endmodule

// ===== src/circular_list_position_engine.sv =====
// ----------------------------------------------------------------------------
// circular_list_position_engine
// ordered store of signed 32-bit entries with positional insert, delete,
// search, reverse and dump; one request at a time, results on a strobe
// codes that fail or need no walk are answered straight from idle; insert and
//   delete shift entries one at a time, each a read then a write; search reads
//   and compares each entry in turn; reverse swaps pairs with two reads and two
//   writes; dump reads and emits each entry in turn; the next request
//   is taken in the cycle that shows the final result of the previous one
// reset clears the entry count and controller, not the entry memory; results
//   cannot be stalled by the receiver
// ----------------------------------------------------------------------------
module circular_list_position_engine
  import clpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [DATA_W-1:0] in_value,
  input  logic [POS_W-1:0]  in_position,
  output logic              out_strobe,
  output logic [STAT_W-1:0] out_status,
  output logic [DATA_W-1:0] out_data,
  output logic [OUT_W-1:0]  out_found_position,
  output logic [OUT_W-1:0]  out_count,
  output logic              out_last
);

  cmd_t cmd;
  sts_t sts;

  clpe_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  clpe_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_value           (in_value),
    .in_position        (in_position),
    .cmd                (cmd),
    .sts                (sts),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_data           (out_data),
    .out_found_position (out_found_position),
    .out_count          (out_count),
    .out_last           (out_last)
  );

endmodule

// ===== src/clpe_checker.sv =====
// ----------------------------------------------------------------------------
// clpe_checker
// port-level checks of request and result sequencing, bound to the top level
// ----------------------------------------------------------------------------
module clpe_checker
  import clpe_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input logic [STAT_W-1:0] out_status,
  input logic [OUT_W-1:0]  out_count,
  input logic              out_last
);

  // a result only follows a request in progress
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy || start))
    else $error("result without a request in progress");

  // more results of the same request keep the engine busy
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |-> busy)
    else $error("engine idle before final result");

  // an accepted request either starts a walk or answers at once
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("accepted request produced nothing");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_count <= OUT_W'(DEPTH)))
    else $error("count beyond depth");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_FULL) |-> (out_count == OUT_W'(DEPTH)))
    else $error("full reported below depth");

endmodule

bind circular_list_position_engine clpe_checker u_clpe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_status (out_status),
  .out_count  (out_count),
  .out_last   (out_last)
);

// ===== tb/sv/circular_list_position_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_list_position_engine_tb
// Checks the list engine against a behavioral list model kept in the bench.
// Directed requests first cover the empty list, the position clamps and the
// one-entry delete case. Random phases then fill the store to full, drain it
// and mix all operations with bursty request timing. Every result strobe is
// compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module circular_list_position_engine_tb;
  import clpe_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 4'd9;
  localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 4'd15;

  typedef struct {
    status_t           status;
    logic [DATA_W-1:0] data;
    logic [OUT_W-1:0]  fpos;
    logic [OUT_W-1:0]  count;
    logic              last;
  } list_result_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [FUNC_W-1:0] in_func;
  logic [DATA_W-1:0] in_value;
  logic [POS_W-1:0]  in_position;
  logic              out_strobe;
  logic [STAT_W-1:0] out_status;
  logic [DATA_W-1:0] out_data;
  logic [OUT_W-1:0]  out_found_position;
  logic [OUT_W-1:0]  out_count;
  logic              out_last;

  logic [DATA_W-1:0] list_mem [DEPTH];
  int                list_len;
  list_result_t      pending_results [$];
  int                fail_count;
  int                cycle_count;
  int                burst_left;

  circular_list_position_engine uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_value           (in_value),
    .in_position        (in_position),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_data           (out_data),
    .out_found_position (out_found_position),
    .out_count          (out_count),
    .out_last           (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t timeout", $time);
    $display("circular_list_position_engine_tb failed");
    $finish;
  end

  function automatic void push_result(status_t st, logic [DATA_W-1:0] dat, int fpos,
                                      logic lst);
    list_result_t r;
    r.status = st;
    r.data   = dat;
    r.fpos   = OUT_W'(fpos);
    r.count  = OUT_W'(list_len);
    r.last   = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_list_op(logic [FUNC_W-1:0] op, logic [DATA_W-1:0] val,
                                          logic [POS_W-1:0] pos);
    status_t           st;
    logic [DATA_W-1:0] dat;
    logic [DATA_W-1:0] tmp;
    int                fpos;
    int                idx;
    int                p;
    st   = ST_OK;
    dat  = '0;
    fpos = 0;
    idx  = 0;
    p    = int'(pos);
    case (op)
      FN_INS_FRONT, FN_INS_END, FN_INS_AT: begin
        if (op == FN_INS_END) idx = list_len;
        else if (op == FN_INS_FRONT || p <= 1) idx = 0;
        else idx = (p - 1 > list_len) ? list_len : p - 1;
        if (list_len >= DEPTH) begin
          st = ST_FULL;
        end else begin
          for (int i = list_len; i > idx; i--) list_mem[i] = list_mem[i-1];
          list_mem[idx] = val;
          list_len++;
        end
      end
      FN_DEL_FRONT, FN_DEL_END, FN_DEL_AT: begin
        if (list_len == 0) st = ST_EMPTY;
        else if (op == FN_DEL_FRONT || (op == FN_DEL_AT && p <= 1)) idx = 0;
        else if (op == FN_DEL_END) idx = list_len - 1;
        else if (list_len == 1) st = ST_BADPOS;
        else idx = (p - 1 < list_len) ? p - 1 : list_len - 1;
        if (st == ST_OK) begin
          dat = list_mem[idx];
          for (int i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      FN_SEARCH: begin
        if (list_len == 0) begin
          st = ST_EMPTY;
        end else begin
          st = ST_MISSING;
          for (int i = 0; i < list_len; i++) begin
            if (st == ST_MISSING && list_mem[i] == val) begin
              st   = ST_OK;
              fpos = i + 1;
            end
          end
        end
      end
      FN_REVERSE: begin
        for (int i = 0; i < list_len / 2; i++) begin
          tmp                     = list_mem[i];
          list_mem[i]             = list_mem[list_len-1-i];
          list_mem[list_len-1-i]  = tmp;
        end
      end
      FN_DUMP: begin
        if (list_len == 0) begin
          st = ST_EMPTY;
        end else begin
          for (int i = 0; i < list_len; i++)
            push_result(ST_OK, list_mem[i], i + 1, i + 1 == list_len);
          return;
        end
      end
      default: ;
    endcase
    push_result(st, dat, fpos, 1'b1);
  endfunction

  task automatic issue_request(input logic [FUNC_W-1:0] op, input logic [DATA_W-1:0] val,
                               input logic [POS_W-1:0] pos);
    in_func     <= op;
    in_value    <= val;
    in_position <= pos;
    start       <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_list_op(op, val, pos);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 4))
      0, 1: return $urandom;
      2: return (list_len > 0) ? list_mem[$urandom_range(0, list_len - 1)] : $urandom;
      3: return $urandom_range(0, 7);
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 3) == 0) return POS_W'($urandom_range(0, 255));
    return POS_W'($urandom_range(0, list_len + 2));
  endfunction

  function automatic logic [FUNC_W-1:0] pick_op(int ins_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) return FUNC_W'($urandom_range(FN_INS_FRONT, FN_INS_AT));
    r = $urandom_range(0, 99);
    if (r < 50) return FUNC_W'($urandom_range(FN_DEL_FRONT, FN_DEL_AT));
    if (r < 75) return FN_SEARCH;
    if (r < 85) return FN_REVERSE;
    if (r < 95) return FN_DUMP;
    return FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
  endfunction

  task automatic run_random_ops(input int n_ops, input int ins_pct);
    logic [FUNC_W-1:0] op;
    for (int i = 0; i < n_ops; i++) begin
      op = pick_op(ins_pct);
      issue_request(op, pick_value(), pick_position());
    end
  endtask

  task automatic test_empty_list();
    issue_request(FN_DEL_FRONT, 32'h1234_5678, 8'd0);
    issue_request(FN_DEL_END, 32'h0, 8'd0);
    issue_request(FN_DEL_AT, 32'h0, 8'd255);
    issue_request(FN_SEARCH, 32'h0, 8'd0);
    issue_request(FN_DUMP, 32'h0, 8'd0);
    issue_request(FN_REVERSE, 32'h0, 8'd0);
  endtask

  task automatic test_edge_positions();
    issue_request(FN_INS_AT, 32'h7fff_ffff, 8'd200);
    issue_request(FN_DEL_AT, 32'h0, 8'd2);
    issue_request(FN_DEL_AT, 32'h0, 8'd255);
    issue_request(FN_REVERSE, 32'h0, 8'd0);
    issue_request(FN_INS_FRONT, 32'h8000_0000, 8'd0);
    issue_request(FN_INS_END, 32'h0000_0000, 8'd0);
    issue_request(FN_INS_AT, 32'hffff_ffff, 8'd0);
    issue_request(FN_INS_AT, 32'h0000_0001, 8'd1);
    issue_request(FN_INS_AT, 32'h5555_aaaa, 8'd255);
    issue_request(FN_INS_AT, 32'haaaa_5555, 8'd3);
    issue_request(FN_SEARCH, 32'h0000_0000, 8'd0);
    issue_request(FN_SEARCH, 32'h1234_5678, 8'd0);
    issue_request(FN_REVERSE, 32'h0, 8'd0);
    issue_request(FN_DUMP, 32'h0, 8'd0);
    issue_request(FN_DEL_AT, 32'h0, 8'd255);
    issue_request(FN_DEL_AT, 32'h0, 8'd0);
    issue_request(FN_DEL_AT, 32'h0, 8'd2);
    issue_request(FN_DEL_FRONT, 32'h0, 8'd0);
    issue_request(FN_DEL_END, 32'h0, 8'd0);
    issue_request(FN_UNUSED_LO, 32'hdead_beef, 8'd7);
    issue_request(FN_UNUSED_HI, 32'hffff_ffff, 8'd255);
  endtask

  task automatic test_fill_to_full();
    run_random_ops(130, 85);
  endtask

  task automatic test_drain();
    run_random_ops(120, 15);
  endtask

  task automatic test_mixed_ops();
    run_random_ops(150, 50);
  endtask

  function automatic void note_mismatch(string field, logic [DATA_W-1:0] exp_v,
                                        logic [DATA_W-1:0] act_v);
    fail_count++;
    $display("%0t %s mismatch: expected %0h actual %0h", $time, field, exp_v, act_v);
  endfunction

  always @(posedge clk) begin
    list_result_t exp_r;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t unexpected result: expected none actual status %0h data %0h",
                 $time, out_status, out_data);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status)
          note_mismatch("status", DATA_W'(exp_r.status), DATA_W'(out_status));
        if (out_data !== exp_r.data) note_mismatch("data", exp_r.data, out_data);
        if (out_found_position !== exp_r.fpos)
          note_mismatch("found_position", DATA_W'(exp_r.fpos), DATA_W'(out_found_position));
        if (out_count !== exp_r.count)
          note_mismatch("count", DATA_W'(exp_r.count), DATA_W'(out_count));
        if (out_last !== exp_r.last)
          note_mismatch("last", DATA_W'(exp_r.last), DATA_W'(out_last));
      end
    end
  end

  initial begin
    fail_count  = 0;
    list_len    = 0;
    burst_left  = 0;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_func     <= '0;
    in_value    <= '0;
    in_position <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_edge_positions();
    test_fill_to_full();
    test_drain();
    test_mixed_ops();

    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("circular_list_position_engine_tb passed");
    end else begin
      $display("circular_list_position_engine_tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/clpe_pkg.sv
src/clpe_ctrl.sv
src/clpe_dpath.sv
src/circular_list_position_engine.sv
src/clpe_checker.sv
tb/sv/circular_list_position_engine_tb.sv
